>>> sv/bti_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bti_pkg
// Shared types and constants for the breakpoint table interpolator.
// ---------------------------------------------------------------------------
package bti_pkg;

    localparam int DEF_MAX_POINTS = 16;

    // Input item mode codes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Quotient bits of the interpolation fraction (value range 0..65536)
    localparam int DIV_STEPS = 17;
    localparam int DCW       = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } state_t;

endpackage

>>> sv/breakpoint_table_interpolator_unit.sv
`timescale 1ns / 1ps
// Flow: an add, or a query on an empty table, goes straight to the output stage; another
//   query scans the breakpoints held (one entry per cycle through the table memory read
//   port) and, between two entries, runs the 17-step divider, multiply and sum first.
// Throughput: one item at a time; the next item is taken once the previous one has
//   moved to the output register.
// Reset: rst_n clears control state, the breakpoint count and default_value.
// ---------------------------------------------------------------------------
// breakpoint_table_interpolator_unit
// Piecewise linear lookup over an insertion-ordered table of Q16.16
// breakpoints held in a synchronous memory.
// ---------------------------------------------------------------------------
module breakpoint_table_interpolator_unit #(
    parameter int MAX_POINTS = bti_pkg::DEF_MAX_POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: default_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key_height, [63:32] point_value
    input  logic [0:0]  s_tuser,   // [0] mode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_value, [36:32] entry_count, [39:37] zero
    output logic [0:0]  m_tuser    // [0] status
);
    import bti_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic signed [33:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [33:0] SAT_LO = -34'sd2147483648;

    // table memory: {value, height}
    logic [63:0] mem [MAX_POINTS];
    logic [63:0] rd_data_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_en;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;
    logic signed [31:0] default_reg;

    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] ph_reg, ph_next;
    logic signed [31:0] pv_reg, pv_next;
    logic signed [32:0] dv_reg, dv_next;
    logic [31:0] den_reg, den_next;
    logic [32:0] rem_reg, rem_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic signed [50:0] prod_reg, prod_next;
    logic signed [31:0] pend_value_reg, pend_value_next;
    logic pend_status_reg, pend_status_next;

    logic m_valid_reg, m_valid_next;
    logic signed [31:0] m_value_reg, m_value_next;
    logic m_status_reg, m_status_next;
    logic [4:0] m_count_reg, m_count_next;

    logic signed [31:0] rd_h;
    logic signed [31:0] rd_v;
    logic signed [32:0] num_diff;
    logic signed [32:0] den_diff;
    logic [32:0] trial;
    logic signed [17:0] frac_s;
    logic signed [50:0] prod_adj;
    logic signed [50:0] step_full;
    logic signed [33:0] sum_full;
    logic [CW+4:0] count_wide;

    assign rd_h = rd_data_reg[31:0];
    assign rd_v = rd_data_reg[63:32];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, m_count_reg, m_value_reg};
    assign m_tuser   = m_status_reg;

    assign num_diff   = 33'(q_reg) - 33'(ph_reg);
    assign den_diff   = 33'(rd_h) - 33'(ph_reg);
    assign trial      = (dcnt_reg == DCW'(DIV_STEPS - 1)) ? rem_reg : {rem_reg[31:0], 1'b0};
    assign frac_s     = {1'b0, quo_reg};
    // truncate toward zero on the divide by 65536
    assign prod_adj   = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd0);
    assign step_full  = prod_adj >>> 16;
    assign sum_full   = 34'(pv_reg) + $signed(step_full[33:0]);
    assign count_wide = (CW + 5)'(count_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {s_tdata[63:32], s_tdata[31:0]};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        dcnt_next        = dcnt_reg;
        q_next           = q_reg;
        ph_next          = ph_reg;
        pv_next          = pv_reg;
        dv_next          = dv_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        prod_next        = prod_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        m_valid_next     = m_valid_reg;
        m_value_next     = m_value_reg;
        m_status_next    = m_status_reg;
        m_count_next     = m_count_reg;
        rd_addr          = '0;
        wr_addr          = count_reg[IW-1:0];
        wr_en            = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pend_status_next = STATUS_OK;
                    pend_value_next  = '0;
                    if (s_tuser[0] == MODE_ADD)
                    begin
                        if (count_reg < CW'(MAX_POINTS))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            pend_status_next = STATUS_FULL;
                        end
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        q_next = s_tdata[31:0];
                        if (count_reg == '0)
                        begin
                            pend_value_next = default_reg;
                            state_next      = ST_OUT;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_h >= q_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        pend_value_next = rd_v;
                        state_next      = ST_OUT;
                    end
                    else
                    begin
                        // previous entry lies strictly below the query, so den > 0
                        den_next   = den_diff[31:0];
                        rem_next   = {1'b0, num_diff[31:0]};
                        dv_next    = 33'(rd_v) - 33'(pv_reg);
                        quo_next   = '0;
                        dcnt_next  = DCW'(DIV_STEPS - 1);
                        state_next = ST_DIV;
                    end
                end
                else if (CW'(idx_reg) == count_reg - CW'(1))
                begin
                    pend_value_next = rd_v;
                    state_next      = ST_OUT;
                end
                else
                begin
                    ph_next  = rd_h;
                    pv_next  = rd_v;
                    idx_next = idx_reg + IW'(1);
                    rd_addr  = idx_reg + IW'(1);
                end
            end

            ST_DIV:
            begin
                // restoring division; first step takes the dividend unshifted
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[DIV_STEPS-2:0], 1'b0};
                end
                if (dcnt_reg == '0)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    dcnt_next = dcnt_reg - DCW'(1);
                end
            end

            ST_MUL:
            begin
                prod_next  = 51'(dv_reg) * 51'(frac_s);
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                if (sum_full > SAT_HI)
                begin
                    pend_value_next = SAT_HI[31:0];
                end
                else if (sum_full < SAT_LO)
                begin
                    pend_value_next = SAT_LO[31:0];
                end
                else
                begin
                    pend_value_next = sum_full[31:0];
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_value_next  = pend_value_reg;
                    m_status_next = pend_status_reg;
                    m_count_next  = count_wide[4:0];
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
            default_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            dcnt_reg    <= dcnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                default_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg           <= q_next;
        ph_reg          <= ph_next;
        pv_reg          <= pv_next;
        dv_reg          <= dv_next;
        den_reg         <= den_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        prod_reg        <= prod_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        m_value_reg     <= m_value_next;
        m_status_reg    <= m_status_next;
        m_count_reg     <= m_count_next;
    end

endmodule

>>> tb/sv/breakpoint_table_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// breakpoint_table_interpolator_unit_tb
// Self-checking bench for the breakpoint table interpolator. A short table
// of directed items (empty table, default register extremes, equal and
// unsorted heights, end points of a segment) is followed by random adds and
// queries biased towards the stored heights. Every result is checked against
// its row's expected value or a local model of the table, with random gaps on
// both streams, one long output hold-off and one stretch with no gaps at all.
// ---------------------------------------------------------------------------
module breakpoint_table_interpolator_unit_tb;

    import bti_pkg::*;

    localparam int MAX_PTS       = DEF_MAX_POINTS;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLDOFF_AT    = 400;
    localparam int HOLDOFF_LEN   = 400;
    localparam int STEADY_FROM   = 1000;
    localparam int STEADY_TO     = 1300;
    localparam int CFG_EVERY     = 450;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [31:0] value;
        logic               status;
        logic [4:0]         count;
    } lookup_res_t;

    typedef struct {
        bit                 set_dflt;
        logic signed [31:0] dflt;
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] pval;
        bit                 typed;
        lookup_res_t        res;
    } stim_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] key_height, [63:32] point_value
    logic [0:0]  s_tuser   = '0;   // [0] mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [31:0] result_value, [36:32] entry_count
    logic [0:0]  m_tuser;          // [0] status

    // model of the table
    logic signed [31:0] bp_height [MAX_PTS];
    logic signed [31:0] bp_value  [MAX_PTS];
    int                 bp_count   = 0;
    logic signed [31:0] dflt_value = '0;

    lookup_res_t pending_results [$];
    stim_row_t   directed_rows [$];
    bit          item_typed;
    lookup_res_t item_res;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          mismatches   = 0;
    int          stall_cycles = 0;

    breakpoint_table_interpolator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [31:0] interp_lookup(input logic signed [31:0] q);
        int     idx;
        longint ql;
        longint ph;
        longint mh;
        longint pv;
        longint mv;
        longint frac;
        longint stepv;
        longint sum;
        if (bp_count == 0)
            return dflt_value;
        idx = bp_count;
        for (int i = 0; i < bp_count; i++)
        begin
            if (bp_height[i] >= q)
            begin
                idx = i;
                break;
            end
        end
        if (idx == bp_count)
            return bp_value[bp_count - 1];
        if (idx == 0)
            return bp_value[0];
        ql = q;
        ph = bp_height[idx - 1];
        mh = bp_height[idx];
        pv = bp_value[idx - 1];
        mv = bp_value[idx];
        if (mh - ph <= 0)
            return bp_value[idx];
        // both divisions truncate towards zero
        frac  = ((ql - ph) * 64'sd65536) / (mh - ph);
        stepv = ((mv - pv) * frac) / 64'sd65536;
        sum   = pv + stepv;
        if (sum > longint'(Q_MAX))
            sum = Q_MAX;
        if (sum < longint'(Q_MIN))
            sum = Q_MIN;
        return sum[31:0];
    endfunction

    function automatic lookup_res_t apply_item(input logic mode, input logic signed [31:0] key,
                                               input logic signed [31:0] pval);
        lookup_res_t r;
        r.value  = '0;
        r.status = STATUS_OK;
        if (mode == MODE_ADD)
        begin
            if (bp_count < MAX_PTS)
            begin
                bp_height[bp_count] = key;
                bp_value[bp_count]  = pval;
                bp_count++;
            end
            else
                r.status = STATUS_FULL;
        end
        else
            r.value = interp_lookup(key);
        r.count = 5'(bp_count);
        return r;
    endfunction

    function automatic lookup_res_t typed_res(input logic signed [31:0] value,
                                              input logic status, input int count);
        lookup_res_t r;
        r.value  = value;
        r.status = status;
        r.count  = 5'(count);
        return r;
    endfunction

    task automatic add_row(input bit set_dflt, input logic signed [31:0] dflt, input logic mode,
                           input logic signed [31:0] key, input logic signed [31:0] pval,
                           input bit typed, input lookup_res_t res);
        stim_row_t row;
        row.set_dflt = set_dflt;
        row.dflt     = dflt;
        row.mode     = mode;
        row.key      = key;
        row.pval     = pval;
        row.typed    = typed;
        row.res      = res;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic offer_item(input logic mode, input logic signed [31:0] key,
                              input logic signed [31:0] pval, input bit typed,
                              input lookup_res_t res);
        while (!(items_sent >= STEADY_FROM && items_sent < STEADY_TO)
               && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {pval, key};
        s_tuser    <= mode;
        item_typed  = typed;
        item_res    = res;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // only written with the stream idle and every result drained
    task automatic write_default(input logic signed [31:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // acceptance, prediction, checking and the stall watchdog
    always @(posedge clk)
    begin : monitor
        lookup_res_t predicted;
        lookup_res_t exp_r;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                dflt_value = cfg_data;
            if (s_tvalid && s_tready)
            begin
                predicted = apply_item(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
                pending_results.insert(pending_results.size(),
                                       item_typed ? item_res : predicted);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    mismatches++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if ($signed(m_tdata[31:0]) !== exp_r.value)
                    begin
                        $error("result_value: expected %0d, got %0d", exp_r.value,
                               $signed(m_tdata[31:0]));
                        mismatches++;
                    end
                    if (m_tuser[0] !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata[36:32] !== exp_r.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", exp_r.count,
                               m_tdata[36:32]);
                        mismatches++;
                    end
                end
            end
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // result side: random back-pressure, one long hold-off, one steady stretch
    initial
    begin : sink
        bit holdoff_done;
        holdoff_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && results_seen >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLDOFF_LEN) @(negedge clk);
            end
            else
                m_tready <= (results_seen >= STEADY_FROM && results_seen < STEADY_TO)
                            || ($urandom_range(99) >= 36);
        end
    end

    initial
    begin : source
        lookup_res_t        no_res;
        stim_row_t          row;
        logic               mode;
        logic signed [31:0] key;
        logic signed [31:0] pval;
        longint             top_height;
        longint             near;
        int                 idx;
        no_res = typed_res('0, STATUS_OK, 0);

        // empty table and the default register
        add_row(0, 0,     MODE_QUERY, 0,     0,  1, typed_res(0, STATUS_OK, 0));
        add_row(1, Q_MIN, MODE_QUERY, Q_MAX, -1, 1, typed_res(Q_MIN, STATUS_OK, 0));
        add_row(1, Q_MAX, MODE_QUERY, Q_MIN, 0,  1, typed_res(Q_MAX, STATUS_OK, 0));
        add_row(1, 32'sh0001_8000, MODE_QUERY, 0, 0, 1,
                typed_res(32'sh0001_8000, STATUS_OK, 0));
        // first segment spans the full value range
        add_row(0, 0, MODE_ADD,   0,     Q_MIN, 1, typed_res(0, STATUS_OK, 1));
        add_row(0, 0, MODE_QUERY, 0,     0,     1, typed_res(Q_MIN, STATUS_OK, 1));
        add_row(0, 0, MODE_QUERY, Q_MAX, 0,     1, typed_res(Q_MIN, STATUS_OK, 1));
        add_row(0, 0, MODE_ADD,   32'sh0001_0000, Q_MAX, 1, typed_res(0, STATUS_OK, 2));
        add_row(0, 0, MODE_QUERY, 32'sh0000_8000, 0, 0, no_res);
        add_row(0, 0, MODE_QUERY, 32'sh0001_0000, 0, 1, typed_res(Q_MAX, STATUS_OK, 2));
        add_row(0, 0, MODE_QUERY, 1,              0, 0, no_res);
        add_row(0, 0, MODE_QUERY, 32'sh0000_ffff, 0, 0, no_res);
        // equal height, then an unsorted one
        add_row(0, 0, MODE_ADD, 32'sh0001_0000, 0, 1, typed_res(0, STATUS_OK, 3));
        add_row(0, 0, MODE_ADD, -32'sh0002_0000, 32'sh1234_5678, 1,
                typed_res(0, STATUS_OK, 4));
        add_row(0, 0, MODE_QUERY, -32'sh0002_0000, 0, 1, typed_res(Q_MIN, STATUS_OK, 4));
        add_row(0, 0, MODE_QUERY, 32'sh0001_0001, 0, 1,
                typed_res(32'sh1234_5678, STATUS_OK, 4));
        // match whose predecessor was never a match itself
        add_row(0, 0, MODE_ADD, 32'sh0003_0000, -32'sh0001_0000, 1,
                typed_res(0, STATUS_OK, 5));
        add_row(0, 0, MODE_QUERY, 32'sh0002_0000, 0, 0, no_res);
        add_row(0, 0, MODE_QUERY, Q_MIN,          0, 0, no_res);
        add_row(0, 0, MODE_QUERY, Q_MAX,          0, 0, no_res);

        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.set_dflt)
                write_default(row.dflt);
            offer_item(row.mode, row.key, row.pval, row.typed, row.res);
        end

        top_height = 32'sh0003_0000;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n > 0 && n % CFG_EVERY == 0)
            begin
                case ((n / CFG_EVERY) % 4)
                    0: write_default(Q_MAX);
                    1: write_default(Q_MIN);
                    2: write_default(0);
                    default: write_default($urandom);
                endcase
            end
            pval = $urandom;
            // adds are frequent until the table is full, then mostly dropped ones
            if ($urandom_range(99) < ((bp_count < MAX_PTS) ? 40 : 15))
            begin
                mode = MODE_ADD;
                // mostly rising heights, so that later entries stay reachable
                if ($urandom_range(3) != 0 && top_height < 64'sd1073741824)
                begin
                    top_height = top_height + $urandom_range(1, 1 << 26);
                    key = top_height[31:0];
                end
                else
                    key = $urandom;
            end
            else
            begin
                mode = MODE_QUERY;
                idx  = (bp_count > 0) ? $urandom_range(bp_count - 1) : 0;
                case ($urandom_range(7))
                    0, 1: key = $urandom;
                    2:
                    begin
                        case ($urandom_range(3))
                            0: key = Q_MIN;
                            1: key = Q_MAX;
                            2: key = Q_MIN + 1;
                            default: key = Q_MAX - 1;
                        endcase
                    end
                    3, 4, 5:
                    begin
                        near = longint'(bp_height[idx]) + $urandom_range(512) - 256;
                        if (near > longint'(Q_MAX))
                            near = Q_MAX;
                        if (near < longint'(Q_MIN))
                            near = Q_MIN;
                        key = near[31:0];
                    end
                    default:
                        key = ($urandom_range(1) == 0 || bp_height[idx] == Q_MAX)
                              ? bp_height[idx] : bp_height[idx] + 1;
                endcase
            end
            offer_item(mode, key, pval, 0, no_res);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
sv/bti_pkg.sv
sv/breakpoint_table_interpolator_unit.sv
tb/sv/breakpoint_table_interpolator_unit_tb.sv
